FILE: hdl/bple_pkg.sv
// shared types and constants of the bounded positional list engine
// no dependencies; used by every other file of the block but bple_ram
package bple_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;

    typedef enum logic [1:0] {
        REQ_FRONT = 2'd0,
        REQ_BACK  = 2'd1,
        REQ_DEL   = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] item;
        logic                     is_last;
        logic                     list_empty;
        logic                     dropped;
    } rsp_word_t;

    // push from the controller into the output queue
    typedef struct packed {
        logic      valid;
        rsp_word_t word;
    } push_t;

    // queue status back to the controller
    typedef struct packed {
        logic [1:0] cnt;
        logic       pop;
    } q_stat_t;

endpackage

FILE: hdl/bple_if.sv
// request and response channel interfaces of the list engine
// depends on bple_pkg for the field widths
interface bple_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic signed [bple_pkg::DATA_W-1:0] value;
    logic [bple_pkg::POS_W-1:0]        position;

    modport source (output valid, req_type, value, position, input ready);
    modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface bple_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [bple_pkg::DATA_W-1:0] item;
    logic                              is_last;
    logic                              list_empty;
    logic                              dropped;

    modport source (output valid, item, is_last, list_empty, dropped, input ready);
    modport sink   (input valid, item, is_last, list_empty, dropped, output ready);
endinterface

FILE: hdl/bple_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bple_outq.sv
// two-word output queue that decouples the list dump from the receiver
// depends on bple_pkg and bple_rsp_if
module bple_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  bple_pkg::push_t   push,
    output bple_pkg::q_stat_t stat,
    bple_rsp_if.source        rsp
);
    import bple_pkg::*;

    rsp_word_t  ent0_reg, ent1_reg;
    rsp_word_t  ent0_next, ent1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop = rsp.valid && rsp.ready;

    always_comb
    begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            ent0_next = ent1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        if (push.valid)
        begin
            if (cnt_next == 2'd0)
            begin
                ent0_next = push.word;
            end
            else
            begin
                ent1_next = push.word;
            end
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign rsp.valid      = cnt_reg != 2'd0;
    assign rsp.item       = ent0_reg.item;
    assign rsp.is_last    = ent0_reg.is_last;
    assign rsp.list_empty = ent0_reg.list_empty;
    assign rsp.dropped    = ent0_reg.dropped;
    assign stat.cnt       = cnt_reg;
    assign stat.pop       = pop;

endmodule

FILE: hdl/bple_ctrl.sv
// request sequencer: insert, shift-down delete and list dump over the element ram
// depends on bple_pkg and bple_req_if
module bple_ctrl #(
    parameter int CAPACITY = bple_pkg::CAPACITY_DEF,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bple_req_if.sink                        req,
    output logic                            ram_we,
    output logic [IW-1:0]                   ram_waddr,
    output logic [bple_pkg::DATA_W-1:0]     ram_wdata,
    output logic                            ram_re,
    output logic [IW-1:0]                   ram_raddr,
    input  logic [bple_pkg::DATA_W-1:0]     ram_rdata,
    output bple_pkg::push_t                 push,
    input  bple_pkg::q_stat_t               stat
);
    import bple_pkg::*;

    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_W  = (CW+1)'(CAPACITY);
    localparam logic [IW-1:0] LAST_S = IW'(CAPACITY - 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          shpend_reg, shpend_next;
    logic          dpend_reg, dpend_next;
    logic          dlast_reg, dlast_next;
    logic          drop_reg, drop_next;

    logic          full;
    logic          pos_lt;
    logic [CW-1:0] pos_c;
    logic          space;
    logic [IW-1:0] front_dec;

    // physical slot of a logical position
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] f, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = {{(CW + 1 - IW){1'b0}}, f} + {1'b0, i};
        if (s >= CAP_W)
        begin
            s = s - CAP_W;
        end
        return s[IW-1:0];
    endfunction

    assign full      = count_reg == CAP_C;
    assign pos_lt    = req.position < POS_W'(count_reg);
    assign pos_c     = CW'(req.position);
    assign front_dec = (front_reg == '0) ? LAST_S : front_reg - IW'(1);
    // queue words plus the read in flight must leave room for one more
    assign space     = ({1'b0, stat.cnt} + {2'b0, dpend_reg}) < (3'd2 + {2'b0, stat.pop});

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        shpend_next = 1'b0;
        dpend_next  = 1'b0;
        dlast_next  = dlast_reg;
        drop_next   = drop_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        req.ready   = state_reg == ST_IDLE;
        push.valid           = dpend_reg;
        push.word.item       = $signed(ram_rdata);
        push.word.is_last    = dlast_reg;
        push.word.list_empty = 1'b0;
        push.word.dropped    = drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    drop_next  = 1'b0;
                    rd_next    = '0;
                    state_next = ST_DUMP;
                    case (req.req_type)
                        REQ_FRONT:
                        begin
                            if (full)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                front_next = front_dec;
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                ram_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_BACK:
                        begin
                            if (full)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot(front_reg, count_reg);
                                ram_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_DEL:
                        begin
                            if (pos_lt)
                            begin
                                if (pos_c == '0)
                                begin
                                    count_next = count_reg - CW'(1);
                                    front_next = (count_reg == CW'(1)) ? '0 :
                                                 slot(front_reg, CW'(1));
                                end
                                else if (pos_c == count_reg - CW'(1))
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                else
                                begin
                                    rd_next    = pos_c + CW'(1);
                                    wr_next    = pos_c;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // read one ahead, write the word back one slot lower next cycle
                if (rd_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = slot(front_reg, rd_reg);
                    rd_next     = rd_reg + CW'(1);
                    shpend_next = 1'b1;
                end
                if (shpend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(front_reg, wr_reg);
                    ram_wdata = ram_rdata;
                    wr_next   = wr_reg + CW'(1);
                end
                if (!(rd_reg < count_reg) && !shpend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    rd_next    = '0;
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (count_reg == '0)
                begin
                    if (space && !dpend_reg)
                    begin
                        push.valid           = 1'b1;
                        push.word.item       = '0;
                        push.word.is_last    = 1'b1;
                        push.word.list_empty = 1'b1;
                        push.word.dropped    = drop_reg;
                        state_next           = ST_IDLE;
                    end
                end
                else if (space)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(front_reg, rd_reg);
                    dpend_next = 1'b1;
                    dlast_next = rd_reg == count_reg - CW'(1);
                    rd_next    = rd_reg + CW'(1);
                    if (rd_reg == count_reg - CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            shpend_reg <= 1'b0;
            dpend_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            shpend_reg <= shpend_next;
            dpend_reg  <= dpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        dlast_reg <= dlast_next;
        drop_reg  <= drop_next;
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (stat.cnt != 2'd2 || stat.pop))
        else $error("push into a full output queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("element count beyond capacity");
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> ram_waddr != ram_raddr)
        else $error("read and write to the same slot in one cycle");
    a_shift_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && state_next == ST_DUMP) |-> !shpend_reg)
        else $error("shift left a write behind");
`endif

endmodule

FILE: hdl/bounded_positional_list_engine_core.sv
// Bounded positional list engine: a deque of up to CAPACITY signed words
// with insert at front, insert at back and delete at a position.
//
// req channel: one word per request (req_type, value, position), taken when
// valid and ready are high. ready is high only while the engine is idle.
// rsp channel: after every request the whole list, front to back, one word
// per element, is_last on the final one; an empty list gives one word with
// list_empty set and item zero. dropped marks every word of an insert into
// a full list.
// Inserts and front/last deletes need no shift; a delete in the middle
// moves every later element down one slot, one ram read and one write
// per cycle. The dump then reads one element per cycle, while the output
// queue has room, from the element ram through a two-word output queue;
// the next request is taken once the dump has issued its last ram read.
// A stalled receiver stops the dump reads once the queue is full; nothing
// is lost. Reset empties the list at once; the ram needs no clearing.
module bounded_positional_list_engine_core #(
    parameter int CAPACITY = bple_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bple_req_if.sink   req,
    bple_rsp_if.source rsp
);
    import bple_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    push_t             push;
    q_stat_t           stat;

    bple_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .push      (push),
        .stat      (stat)
    );

    bple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bple_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule
